[rtl/ndg_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and command/status structs of the Moore neighborhood grid block.
package ndg_pkg;

  // Fixed widths of the grid fields.
  localparam int MAX_DIMS  = 3;
  localparam int LANES     = 3;
  localparam int COORD_W   = 13;
  localparam int SIZE_W    = 13;
  localparam int POS_W     = COORD_W + 1;
  localparam int STRIDE_W  = 2 * SIZE_W;
  localparam int MULB_W    = STRIDE_W + 1;
  localparam int PROD_W    = POS_W + MULB_W;
  localparam int IDX_W     = PROD_W + 1;
  localparam int CELL_W    = 32;
  localparam int BITS_W    = 27;
  localparam int BIT_IDX_W = 5;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic        [SIZE_W-1:0]   extent_t;
  typedef logic signed [POS_W-1:0]    pos_t;
  typedef logic        [STRIDE_W-1:0] stride_t;
  typedef logic signed [MULB_W-1:0]   mulb_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [IDX_W-1:0]    idx_t;
  typedef logic        [CELL_W-1:0]   cell_t;
  typedef logic        [BITS_W-1:0]   nbits_t;
  typedef logic        [BIT_IDX_W-1:0] bit_idx_t;
  typedef logic        [1:0]          digit_t;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_GATHER = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DIM_COUNT  = 2'd0,
    REG_DIM_SIZE_0 = 2'd1,
    REG_DIM_SIZE_1 = 2'd2,
    REG_DIM_SIZE_2 = 2'd3
  } reg_idx_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_STRIDE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_WRITE,
    S_READ,
    S_WALK,
    S_DRAIN,
    S_RESULT
  } state_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_STRIDE,
    MUL_POS0,
    MUL_POS1
  } mul_op_t;

  // Index accumulator operations.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_PROD,
    ACC_ADD_POS2,
    ACC_STEP
  } acc_op_t;

  typedef struct packed {
    logic    load;
    logic    clear_step;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    ram_write;
    logic    issue;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic  clear_last;
    logic  walk_last;
    mode_t mode;
  } dp_status_t;

endpackage

[rtl/ndg_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ndg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/ndg_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine that sequences clearing, index arithmetic and cell accesses.
module ndg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             mode,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ndg_pkg::dp_cmd_t       cmd,
  input  ndg_pkg::dp_status_t    status
);

  ndg_pkg::state_t state;
  ndg_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ndg_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag: set when a result is loaded, cleared when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.mul_op     = ndg_pkg::MUL_IDLE;
    cmd.acc_op     = ndg_pkg::ACC_HOLD;
    unique case (state)
      ndg_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ndg_pkg::S_IDLE;
        end
      end
      ndg_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (ndg_pkg::mode_t'(mode) == ndg_pkg::MODE_NONE) begin
            state_next = ndg_pkg::S_RESULT;
          end else begin
            state_next = ndg_pkg::S_STRIDE;
          end
        end
      end
      ndg_pkg::S_STRIDE: begin
        cmd.mul_op = ndg_pkg::MUL_STRIDE;
        state_next = ndg_pkg::S_MUL0;
      end
      ndg_pkg::S_MUL0: begin
        cmd.mul_op = ndg_pkg::MUL_POS0;
        state_next = ndg_pkg::S_MUL1;
      end
      ndg_pkg::S_MUL1: begin
        cmd.mul_op = ndg_pkg::MUL_POS1;
        cmd.acc_op = ndg_pkg::ACC_LOAD;
        state_next = ndg_pkg::S_MUL2;
      end
      ndg_pkg::S_MUL2: begin
        cmd.acc_op = ndg_pkg::ACC_ADD_PROD;
        state_next = ndg_pkg::S_MUL3;
      end
      ndg_pkg::S_MUL3: begin
        cmd.acc_op = ndg_pkg::ACC_ADD_POS2;
        unique case (status.mode)
          ndg_pkg::MODE_WRITE: state_next = ndg_pkg::S_WRITE;
          ndg_pkg::MODE_READ:  state_next = ndg_pkg::S_READ;
          default:             state_next = ndg_pkg::S_WALK;
        endcase
      end
      ndg_pkg::S_WRITE: begin
        cmd.ram_write = 1'b1;
        state_next    = ndg_pkg::S_RESULT;
      end
      ndg_pkg::S_READ: begin
        cmd.issue  = 1'b1;
        state_next = ndg_pkg::S_DRAIN;
      end
      ndg_pkg::S_WALK: begin
        cmd.issue  = 1'b1;
        cmd.acc_op = ndg_pkg::ACC_STEP;
        if (status.walk_last) begin
          state_next = ndg_pkg::S_DRAIN;
        end
      end
      ndg_pkg::S_DRAIN: begin
        state_next = ndg_pkg::S_RESULT;
      end
      ndg_pkg::S_RESULT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ndg_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ndg_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/ndg_datapath.sv]
`timescale 1ns / 1ps
// Datapath: coordinate lanes, shared multiplier, index accumulator, neighbor walk and cell RAM.
module ndg_datapath #(
  parameter int CELL_COUNT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ndg_pkg::dp_cmd_t      cmd,
  output ndg_pkg::dp_status_t   status,
  input  logic [1:0]            dim_count,
  input  ndg_pkg::extent_t      dim_size_0,
  input  ndg_pkg::extent_t      dim_size_1,
  input  ndg_pkg::extent_t      dim_size_2,
  input  logic [1:0]            mode,
  input  ndg_pkg::coord_t       coord_0,
  input  ndg_pkg::coord_t       coord_1,
  input  ndg_pkg::coord_t       coord_2,
  input  ndg_pkg::cell_t        write_value,
  output ndg_pkg::cell_t        read_value,
  output ndg_pkg::nbits_t       neighbor_bits,
  output logic                  out_of_bounds
);

  localparam int AW = $clog2(CELL_COUNT);
  localparam int LN = ndg_pkg::LANES;

  // Item registers. Lane 2 holds the fastest dimension in use; unused lanes sit at zero.
  ndg_pkg::mode_t     mode_r;
  ndg_pkg::cell_t     wv;
  logic [LN-1:0]      lane_act;
  ndg_pkg::extent_t   lane_size [LN];
  ndg_pkg::pos_t      pos [LN];
  ndg_pkg::digit_t    dig [LN];
  ndg_pkg::bit_idx_t  count;
  ndg_pkg::bit_idx_t  last_count;

  // Arithmetic registers.
  ndg_pkg::stride_t   st0;
  ndg_pkg::idx_t      prod;
  ndg_pkg::idx_t      acc;
  ndg_pkg::idx_t      delta1;
  ndg_pkg::idx_t      delta2;

  // Read pipeline and result registers.
  logic               pipe_live;
  logic               pipe_ok;
  ndg_pkg::bit_idx_t  pipe_bit;
  ndg_pkg::cell_t     rv;
  ndg_pkg::nbits_t    bits;
  logic               oob;
  logic [AW-1:0]      clr_addr;

  // Combinational signals.
  logic [1:0]         dims;
  logic [LN-1:0]      act_in;
  ndg_pkg::coord_t    c_in [LN];
  ndg_pkg::extent_t   s_in [LN];
  ndg_pkg::bit_idx_t  last_in;
  ndg_pkg::pos_t      start_off;
  ndg_pkg::pos_t      mul_a;
  ndg_pkg::mulb_t     mul_b;
  ndg_pkg::prod_t     prod_c;
  logic [LN-1:0]      lane_ok;
  logic               flat_ok;
  logic               point_ok;
  logic               is_center;
  logic               carry2;
  logic               carry1;
  ndg_pkg::idx_t      step_delta;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  ndg_pkg::cell_t     ram_wdata;
  ndg_pkg::cell_t     rd_data;

  // Active dimension count, with zero taken as one.
  always_comb begin
    dims = (dim_count == 2'd0) ? 2'd1 : dim_count;
    if (dims > 2'(ndg_pkg::MAX_DIMS)) begin
      dims = 2'(ndg_pkg::MAX_DIMS);
    end
  end

  // Map the dimensions in use onto lanes so that the last one always lands in lane 2.
  always_comb begin
    act_in  = '0;
    last_in = '0;
    for (int j = 0; j < LN; j++) begin
      c_in[j] = '0;
      s_in[j] = '0;
    end
    unique case (dims)
      2'd1: begin
        act_in  = 3'b100;
        c_in[2] = coord_0;
        s_in[2] = dim_size_0;
        last_in = 5'd2;
      end
      2'd2: begin
        act_in  = 3'b110;
        c_in[1] = coord_0;
        s_in[1] = dim_size_0;
        c_in[2] = coord_1;
        s_in[2] = dim_size_1;
        last_in = 5'd8;
      end
      default: begin
        act_in  = 3'b111;
        c_in[0] = coord_0;
        s_in[0] = dim_size_0;
        c_in[1] = coord_1;
        s_in[1] = dim_size_1;
        c_in[2] = coord_2;
        s_in[2] = dim_size_2;
        last_in = 5'd26;
      end
    endcase
    start_off = (ndg_pkg::mode_t'(mode) == ndg_pkg::MODE_GATHER) ? ndg_pkg::pos_t'(1) : '0;
  end

  // Shared multiplier: stride product, then the two upper lane terms of the flat index.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      ndg_pkg::MUL_STRIDE: begin
        mul_a = ndg_pkg::pos_t'(lane_size[1]);
        mul_b = ndg_pkg::mulb_t'(lane_size[2]);
      end
      ndg_pkg::MUL_POS0: begin
        mul_a = pos[0];
        mul_b = ndg_pkg::mulb_t'(st0);
      end
      ndg_pkg::MUL_POS1: begin
        mul_a = pos[1];
        mul_b = ndg_pkg::mulb_t'(lane_size[2]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // Range check of the current point: every lane in use within its extent, flat index in store.
  always_comb begin
    for (int j = 0; j < LN; j++) begin
      lane_ok[j] = !lane_act[j] ||
                   (!pos[j][ndg_pkg::POS_W-1] && (pos[j][ndg_pkg::POS_W-2:0] < lane_size[j]));
    end
    flat_ok   = !acc[ndg_pkg::IDX_W-1] && (acc < ndg_pkg::idx_t'(CELL_COUNT));
    point_ok  = (&lane_ok) && flat_ok;
    is_center = (!lane_act[0] || dig[0] == 2'd1) &&
                (!lane_act[1] || dig[1] == 2'd1) &&
                (!lane_act[2] || dig[2] == 2'd1);
  end

  // Odometer carries and the matching index change.
  always_comb begin
    carry2 = (dig[2] == 2'd2);
    carry1 = carry2 && (dig[1] == 2'd2);
    if (carry1) begin
      step_delta = delta2;
    end else if (carry2) begin
      step_delta = delta1;
    end else begin
      step_delta = ndg_pkg::idx_t'(1);
    end
  end

  // Lane, digit and count registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= ndg_pkg::mode_t'(mode);
      wv         <= write_value;
      lane_act   <= act_in;
      last_count <= last_in;
      count      <= '0;
      for (int j = 0; j < LN; j++) begin
        lane_size[j] <= s_in[j];
        pos[j]       <= act_in[j] ? (ndg_pkg::pos_t'(c_in[j]) - start_off) : '0;
        dig[j]       <= '0;
      end
    end else begin
      if (cmd.issue) begin
        count <= count + 5'd1;
      end
      if (cmd.acc_op == ndg_pkg::ACC_STEP) begin
        if (!carry2) begin
          dig[2] <= dig[2] + 2'd1;
          pos[2] <= pos[2] + ndg_pkg::pos_t'(1);
        end else begin
          dig[2] <= '0;
          pos[2] <= pos[2] - ndg_pkg::pos_t'(2);
          if (!carry1) begin
            dig[1] <= dig[1] + 2'd1;
            pos[1] <= pos[1] + ndg_pkg::pos_t'(1);
          end else begin
            dig[1] <= '0;
            pos[1] <= pos[1] - ndg_pkg::pos_t'(2);
            dig[0] <= dig[0] + 2'd1;
            pos[0] <= pos[0] + ndg_pkg::pos_t'(1);
          end
        end
      end
    end
  end

  // Stride, product and carry deltas.
  always_ff @(posedge clk) begin
    if (cmd.mul_op == ndg_pkg::MUL_STRIDE) begin
      st0 <= prod_c[ndg_pkg::STRIDE_W-1:0];
    end
    if (cmd.mul_op == ndg_pkg::MUL_POS0 || cmd.mul_op == ndg_pkg::MUL_POS1) begin
      prod <= ndg_pkg::idx_t'(prod_c);
    end
    if (cmd.mul_op == ndg_pkg::MUL_POS0) begin
      delta1 <= ndg_pkg::idx_t'(lane_size[2]) - ndg_pkg::idx_t'(2);
      delta2 <= ndg_pkg::idx_t'(st0) - ndg_pkg::idx_t'({lane_size[2], 1'b0})
                - ndg_pkg::idx_t'(2);
    end
  end

  // Flat index accumulator.
  always_ff @(posedge clk) begin
    unique case (cmd.acc_op)
      ndg_pkg::ACC_LOAD:     acc <= prod;
      ndg_pkg::ACC_ADD_PROD: acc <= acc + prod;
      ndg_pkg::ACC_ADD_POS2: acc <= acc + ndg_pkg::idx_t'(pos[2]);
      ndg_pkg::ACC_STEP:     acc <= acc + step_delta;
      default:               acc <= acc;
    endcase
  end

  // Clearing pass address after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // RAM write mux: zero fill during the clearing pass, else an in-range write request.
  always_comb begin
    ram_we    = cmd.clear_step || (cmd.ram_write && point_ok);
    ram_waddr = cmd.clear_step ? clr_addr : acc[AW-1:0];
    ram_wdata = cmd.clear_step ? '0 : wv;
  end

  ndg_ram #(
    .WIDTH (ndg_pkg::CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (acc[AW-1:0]),
    .rd_data (rd_data)
  );

  // Track which issued read returns in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_live <= 1'b0;
    end else begin
      pipe_live <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    pipe_ok  <= point_ok;
    pipe_bit <= count;
  end

  // Result accumulation: read value, neighbor bits and range flag.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rv   <= '0;
      bits <= '0;
      oob  <= 1'b0;
    end else begin
      if ((cmd.issue || cmd.ram_write) && (mode_r != ndg_pkg::MODE_GATHER || is_center)) begin
        oob <= !point_ok;
      end
      if (pipe_live) begin
        if (mode_r == ndg_pkg::MODE_READ) begin
          rv <= pipe_ok ? rd_data : '0;
        end else if (pipe_ok && rd_data == ndg_pkg::cell_t'(1)) begin
          bits[pipe_bit] <= 1'b1;
        end
      end
    end
  end

  // Output registers.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value    <= rv;
      neighbor_bits <= bits;
      out_of_bounds <= oob;
    end
  end

  // Status to the controller.
  always_comb begin
    status.clear_last = (clr_addr == AW'(CELL_COUNT - 1));
    status.walk_last  = (count == last_count);
    status.mode       = mode_r;
  end

endmodule

[rtl/nd_grid_moore_neighborhood_core.sv]
`timescale 1ns / 1ps
// Top level of the Moore neighborhood grid block: configuration registers and unit wiring.
//
// Requests enter on in_valid/in_stall with mode, coord_0..2 and write_value; each request
// gives exactly one result on out_valid/out_stall (read_value, neighbor_bits,
// out_of_bounds). A request is taken when in_valid is high and in_stall is low.
// Grid shape comes from dim_count and dim_size_0..2, written through the APB port at
// byte addresses 0, 4, 8 and 12; write them only while no request is in flight.
// After acceptance a request runs through S_STRIDE and S_MUL0 to S_MUL3, then S_WRITE
// for a write, S_READ and S_DRAIN for a read, or S_WALK over all 3^d neighbors
// (d dimensions in use) and S_DRAIN for a gather; an unused mode goes straight to S_RESULT.
// The block works on one request at a time and takes the next one the cycle after the
// result is loaded. The gather time is set by the single read port of the cell RAM, which
// reads one neighbor per cycle; index setup uses the shared multiplier in S_STRIDE to S_MUL1.
// After reset the cell RAM is cleared one cell per cycle with in_stall held high;
// configuration writes are taken during that time.
// A stalled result stays in the output register; a following request may still be
// accepted and is worked on, but its result waits until the receiver takes the first.
module nd_grid_moore_neighborhood_core #(
  parameter int CELL_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [12:0] coord_0,
  input  logic signed [12:0] coord_1,
  input  logic signed [12:0] coord_2,
  input  logic signed [31:0] write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic [26:0]        neighbor_bits,
  output logic               out_of_bounds,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [1:0]            dim_count;
  ndg_pkg::extent_t      dim_size_0;
  ndg_pkg::extent_t      dim_size_1;
  ndg_pkg::extent_t      dim_size_2;
  logic                  cfg_write;
  ndg_pkg::reg_idx_t     cfg_sel;
  ndg_pkg::dp_cmd_t      cmd;
  ndg_pkg::dp_status_t   status;
  ndg_pkg::cell_t        rv_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = ndg_pkg::reg_idx_t'(paddr[3:2]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count  <= 2'd3;
      dim_size_0 <= 13'd16;
      dim_size_1 <= 13'd16;
      dim_size_2 <= 13'd16;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        ndg_pkg::REG_DIM_COUNT:  dim_count  <= pwdata[1:0];
        ndg_pkg::REG_DIM_SIZE_0: dim_size_0 <= pwdata[ndg_pkg::SIZE_W-1:0];
        ndg_pkg::REG_DIM_SIZE_1: dim_size_1 <= pwdata[ndg_pkg::SIZE_W-1:0];
        ndg_pkg::REG_DIM_SIZE_2: dim_size_2 <= pwdata[ndg_pkg::SIZE_W-1:0];
        default:                 dim_count  <= dim_count;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (cfg_sel)
      ndg_pkg::REG_DIM_COUNT:  prdata = 32'(dim_count);
      ndg_pkg::REG_DIM_SIZE_0: prdata = 32'(dim_size_0);
      ndg_pkg::REG_DIM_SIZE_1: prdata = 32'(dim_size_1);
      ndg_pkg::REG_DIM_SIZE_2: prdata = 32'(dim_size_2);
      default:                 prdata = '0;
    endcase
  end

  ndg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  ndg_datapath #(
    .CELL_COUNT (CELL_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .dim_count     (dim_count),
    .dim_size_0    (dim_size_0),
    .dim_size_1    (dim_size_1),
    .dim_size_2    (dim_size_2),
    .mode          (mode),
    .coord_0       (coord_0),
    .coord_1       (coord_1),
    .coord_2       (coord_2),
    .write_value   (write_value),
    .read_value    (rv_out),
    .neighbor_bits (neighbor_bits),
    .out_of_bounds (out_of_bounds)
  );

  assign read_value = rv_out;

endmodule

[tb/sv/nd_grid_moore_neighborhood_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the Moore neighborhood grid core with its own grid predictor.
module nd_grid_moore_neighborhood_core_test;
  import ndg_pkg::*;

  localparam int CELLS       = 4096;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0] op;
    coord_t     c0;
    coord_t     c1;
    coord_t     c2;
    cell_t      wv;
  } request_t;

  typedef struct packed {
    cell_t  rv;
    nbits_t nb;
    logic   oob;
  } outcome_t;

  // Ports of the block; every input starts at a known value.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_WRITE;
  coord_t             coord_0 = '0;
  coord_t             coord_1 = '0;
  coord_t             coord_2 = '0;
  logic signed [31:0] write_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] read_value;
  logic [26:0]        neighbor_bits;
  logic               out_of_bounds;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor copy of the grid shape and the cell store.
  logic [1:0] grid_dims;
  extent_t    grid_size [3];
  cell_t      grid_cells [CELLS];

  request_t pending_q [$];
  outcome_t outcome_q [$];
  request_t cur_req;
  int       focus [3];

  int  cycle_count = 0;
  int  fault_count = 0;
  int  requests_taken = 0;
  int  results_seen = 0;
  int  shapes_used = 0;
  int  gather_hits = 0;
  int  oob_count = 0;
  int  burst_left = 1;
  int  gap_left = 0;
  int  hold_left = 0;
  bit  hold_done [2];
  int  pat_mode = 0;
  int  pat_left = 0;
  int  pat_phase = 0;

  nd_grid_moore_neighborhood_core #(.CELL_COUNT(CELLS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .coord_0(coord_0), .coord_1(coord_1), .coord_2(coord_2),
    .write_value(write_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .neighbor_bits(neighbor_bits), .out_of_bounds(out_of_bounds),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Row-major cell index of a point; returns 0 when it falls outside the grid or the store.
  function automatic bit cell_index(input int p0, input int p1, input int p2, input int dims,
                                    output int idx);
    int     p [3];
    longint index;
    longint mult;
    int     k;
    p[0] = p0;
    p[1] = p1;
    p[2] = p2;
    index = 0;
    mult = 1;
    idx = 0;
    for (k = dims - 1; k >= 0; k--) begin
      if (p[k] < 0 || p[k] >= int'(grid_size[k])) return 1'b0;
      index += longint'(p[k]) * mult;
      mult *= longint'(grid_size[k]);
    end
    if (index >= CELLS) return 1'b0;
    idx = int'(index);
    return 1'b1;
  endfunction

  // Applies one request to the predicted grid and returns the result it must give.
  function automatic outcome_t apply_request(input request_t rq);
    outcome_t o;
    int       c [3];
    int       p [3];
    int       dims;
    int       idx;
    int       nidx;
    int       total;
    int       i;
    int       k;
    int       rem;
    bit       ok;
    o = '0;
    c[0] = int'(rq.c0);
    c[1] = int'(rq.c1);
    c[2] = int'(rq.c2);
    dims = (grid_dims == 2'd0) ? 1 : int'(grid_dims);
    if (rq.op != MODE_NONE) begin
      ok = cell_index(c[0], c[1], c[2], dims, idx);
      o.oob = !ok;
      case (rq.op)
        MODE_WRITE: begin
          if (ok) grid_cells[idx] = rq.wv;
        end
        MODE_READ: begin
          if (ok) o.rv = grid_cells[idx];
        end
        default: begin
          total = 1;
          for (k = 0; k < dims; k++) total *= 3;
          for (i = 0; i < total; i++) begin
            rem = i;
            p = c;
            for (k = dims - 1; k >= 0; k--) begin
              p[k] = c[k] + (rem % 3) - 1;
              rem = rem / 3;
            end
            if (cell_index(p[0], p[1], p[2], dims, nidx) && grid_cells[nidx] == 32'd1)
              o.nb[i] = 1'b1;
          end
        end
      endcase
    end
    return o;
  endfunction

  // Sender: bursts of requests with random gaps; a stalled request is held unchanged.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want = apply_request(cur_req);
        if (want.nb != '0) gather_hits++;
        if (want.oob) oob_count++;
        outcome_q.push_back(want);
        requests_taken++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_req = pending_q.pop_front();
        mode <= cur_req.op;
        coord_0 <= cur_req.c0;
        coord_1 <= cur_req.c1;
        coord_2 <= cur_req.c2;
        write_value <= cur_req.wv;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(24, 1);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a random stall pattern that is drawn anew when its run ends, plus two long hold-offs.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done[0] && results_seen >= 250) begin
      hold_done[0] = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (!hold_done[1] && results_seen >= 1100) begin
      hold_done[1] = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(3);
        pat_left = $urandom_range(256, 64);
      end
      pat_left--;
      pat_phase++;
      case (pat_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(9) < 3);
        2: out_stall <= ((pat_phase % 8) < 3);
        default: out_stall <= ($urandom_range(9) < 7);
      endcase
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("Result with no request waiting: read_value %h neighbor_bits %h oob %b",
                   read_value, neighbor_bits, out_of_bounds);
      end else begin
        want = outcome_q.pop_front();
        if (read_value !== want.rv || neighbor_bits !== want.nb
            || out_of_bounds !== want.oob) begin
          fault_count++;
          if (fault_count <= 10)
            $display("Mismatch at result %0d: read_value %h/%h neighbor_bits %h/%h oob %b/%b",
                     results_seen, want.rv, read_value, want.nb, neighbor_bits,
                     want.oob, out_of_bounds);
        end
      end
    end
  end

  // Cycle limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // One APB write, setup then access; the predictor follows the new value.
  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_DIM_COUNT:  grid_dims = v[1:0];
      REG_DIM_SIZE_0: grid_size[0] = v[SIZE_W-1:0];
      REG_DIM_SIZE_1: grid_size[1] = v[SIZE_W-1:0];
      default:        grid_size[2] = v[SIZE_W-1:0];
    endcase
  endtask

  // Waits until every request has been taken and answered, then waits on before returning.
  // The check runs on the falling edge so that the sender's updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || outcome_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic void queue_req(input logic [1:0] op, input int c0, input int c1,
                                    input int c2, input logic [31:0] wv);
    request_t rq;
    rq.op = op;
    rq.c0 = coord_t'(c0);
    rq.c1 = coord_t'(c1);
    rq.c2 = coord_t'(c2);
    rq.wv = wv;
    pending_q.push_back(rq);
  endfunction

  // Picks a point of interest, often on a grid edge; a low focus keeps the flat index small.
  function automatic void move_focus(input bit low, input int dims);
    int k;
    int lim;
    for (k = 0; k < 3; k++) begin
      lim = (grid_size[k] == 0) ? 0 : ((grid_size[k] > CELLS) ? CELLS - 1 : grid_size[k] - 1);
      if (low) begin
        focus[k] = (k == dims - 1) ? $urandom_range(lim) : 0;
      end else begin
        case ($urandom_range(2))
          0: focus[k] = 0;
          1: focus[k] = lim;
          default: focus[k] = $urandom_range(lim);
        endcase
      end
    end
  endfunction

  // Coordinate mostly near the focus, sometimes anywhere in or just off the grid, or raw.
  function automatic int pick_coord(input int k);
    int r;
    r = $urandom_range(99);
    if (r < 70) return focus[k] + $urandom_range(4) - 2;
    if (r < 88) return int'($urandom_range(grid_size[k])) - int'($urandom_range(1));
    return $urandom_range(8191);
  endfunction

  // One grid shape, then a run of random requests under it.
  task automatic run_shape(input logic [1:0] dims, input int s0, input int s1, input int s2,
                           input int count, input bit low);
    int n;
    int r;
    int d;
    logic [1:0] op;
    logic [31:0] wv;
    wait_drained();
    write_reg(REG_DIM_COUNT, {30'd0, dims});
    write_reg(REG_DIM_SIZE_0, s0);
    write_reg(REG_DIM_SIZE_1, s1);
    write_reg(REG_DIM_SIZE_2, s2);
    shapes_used++;
    d = (dims == 2'd0) ? 1 : int'(dims);
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) move_focus(low, d);
      r = $urandom_range(99);
      op = (r < 40) ? MODE_WRITE : (r < 60) ? MODE_READ : (r < 95) ? MODE_GATHER : MODE_NONE;
      r = $urandom_range(99);
      wv = (r < 60) ? 32'd1 : (r < 75) ? 32'd0 : $urandom;
      queue_req(op, pick_coord(0), pick_coord(1), pick_coord(2), wv);
    end
  endtask

  // Reset, directed requests under the reset shape, then random phases over many shapes.
  initial begin
    grid_dims = 2'd3;
    grid_size[0] = 13'd16;
    grid_size[1] = 13'd16;
    grid_size[2] = 13'd16;
    foreach (grid_cells[i]) grid_cells[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Corners, extreme values, a near miss of one, and out-of-range points.
    queue_req(MODE_WRITE, 0, 0, 0, 32'd1);
    queue_req(MODE_WRITE, 0, 0, 1, 32'd1);
    queue_req(MODE_WRITE, 1, 1, 1, 32'd1);
    queue_req(MODE_WRITE, 15, 15, 15, 32'd1);
    queue_req(MODE_WRITE, 15, 15, 14, 32'd2);
    queue_req(MODE_WRITE, 14, 14, 14, 32'h8000_0000);
    queue_req(MODE_WRITE, 8, 8, 8, 32'h7FFF_FFFF);
    queue_req(MODE_WRITE, 16, 0, 0, 32'd1);
    queue_req(MODE_WRITE, -4096, 4095, -1, 32'd5);
    queue_req(MODE_READ, 0, 0, 0, 32'd0);
    queue_req(MODE_READ, 14, 14, 14, 32'd0);
    queue_req(MODE_READ, 8, 8, 8, 32'd0);
    queue_req(MODE_READ, 16, 0, 0, 32'd0);
    queue_req(MODE_READ, -1, 0, 0, 32'd0);
    queue_req(MODE_GATHER, 0, 0, 0, 32'd0);
    queue_req(MODE_GATHER, 15, 15, 15, 32'd0);
    queue_req(MODE_GATHER, -1, -1, -1, 32'd0);
    queue_req(MODE_GATHER, 16, 16, 16, 32'd0);
    queue_req(MODE_GATHER, 8, 8, 8, 32'd0);
    queue_req(MODE_NONE, 1, 1, 1, 32'hFFFF_FFFF);
    queue_req(MODE_GATHER, 1, 1, 1, 32'd0);
    queue_req(MODE_READ, 1, 1, 1, 32'd0);
    queue_req(MODE_WRITE, 4095, -4096, 4095, 32'd1);
    queue_req(MODE_GATHER, -4096, -4096, -4096, 32'd0);

    // Shapes: widest line, squares, zero count, grids beyond the store, zero and unit extents.
    run_shape(2'd1, 4096, 3, 9, 220, 1'b0);
    run_shape(2'd2, 64, 64, 1, 220, 1'b0);
    run_shape(2'd3, 16, 16, 16, 240, 1'b0);
    run_shape(2'd0, 8, 5, 7, 160, 1'b0);
    run_shape(2'd3, 8191, 8191, 8191, 180, 1'b1);
    run_shape(2'd2, 0, 5, 5, 120, 1'b0);
    run_shape(2'd3, 1, 1, 1, 120, 1'b0);
    run_shape(2'd3, 4, 8, 16, 220, 1'b0);
    run_shape(2'd3, $urandom_range(20, 1), $urandom_range(20, 1), $urandom_range(20, 1),
              200, 1'b0);
    run_shape(2'd3, 4096, 1, 1, 170, 1'b0);
    wait_drained();
    if (outcome_q.size() != 0) fault_count++;

    $display("Checked %0d results of %0d requests across %0d grid shapes.",
             results_seen, requests_taken, shapes_used);
    $display("Gathers that found a neighbor: %0d; out-of-range requests: %0d; faults: %0d.",
             gather_hits, oob_count, fault_count);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
